// ===== rtl/core/bpt_pkg.sv =====
// Package for the barycentric point-in-triangle block.
// Holds the control bundle that travels along the divider cells.
`default_nettype none
package bpt_pkg;

	localparam int QBITS = 15;

	typedef struct packed {
		logic valid;
		logic degen;
		logic in_tri;
		logic neg_u;
		logic neg_v;
		logic sat_u;
		logic sat_v;
	} ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/bpt_front.sv =====
// Front pipeline: edge vectors, cross products, sign normalization, the
// exact inside test and the saturation flags. Depends on bpt_pkg.
`default_nettype none
module bpt_front #(
	parameter int W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [W-1:0]     ax,
	input  wire logic [W-1:0]     ay,
	input  wire logic [W-1:0]     bx,
	input  wire logic [W-1:0]     by_coord,
	input  wire logic [W-1:0]     cx,
	input  wire logic [W-1:0]     cy,
	input  wire logic [W-1:0]     qx,
	input  wire logic [W-1:0]     qy,
	output bpt_pkg::ctl_t         ctl_s4,
	output logic [2*W+2:0]        d_s4,
	output logic [2*W+2:0]        ru_s4,
	output logic [2*W+2:0]        rv_s4
);
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;

	logic                 v_s1, v_s2, v_s3;
	logic signed [DW-1:0] e0x_s1, e0y_s1, e1x_s1, e1y_s1, wx_s1, wy_s1;
	logic signed [PW-1:0] pd0_s2, pd1_s2, pu0_s2, pu1_s2, pv0_s2, pv1_s2;
	logic signed [CW-1:0] d_s3, nu_s3, nv_s3;

	logic signed [CW-1:0] dn, nun, nvn;
	logic signed [CW:0]   sum_uv;
	logic        [CW-1:0] mag_u, mag_v;
	logic        [CW:0]   twice_d;
	logic                 dneg;

	function automatic logic signed [DW-1:0] sub_ext(input logic [W-1:0] p,
			input logic [W-1:0] q);
		return $signed({p[W-1], p}) - $signed({q[W-1], q});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ctl_s4 <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			ctl_s4.valid <= v_s3;
			ctl_s4.degen <= (d_s3 == '0);
			ctl_s4.in_tri <= (d_s3 != '0) && !nun[CW-1] && !nvn[CW-1] &&
				(sum_uv <= $signed({dn[CW-1], dn}));
			ctl_s4.neg_u <= nun[CW-1];
			ctl_s4.neg_v <= nvn[CW-1];
			ctl_s4.sat_u <= (twice_d <= {1'b0, mag_u});
			ctl_s4.sat_v <= (twice_d <= {1'b0, mag_v});
		end
	end

	always_ff @(posedge clk) begin
		e0x_s1 <= sub_ext(cx, ax);
		e0y_s1 <= sub_ext(cy, ay);
		e1x_s1 <= sub_ext(bx, ax);
		e1y_s1 <= sub_ext(by_coord, ay);
		wx_s1 <= sub_ext(qx, ax);
		wy_s1 <= sub_ext(qy, ay);
		pd0_s2 <= e0x_s1 * e1y_s1;
		pd1_s2 <= e1x_s1 * e0y_s1;
		pu0_s2 <= wx_s1 * e1y_s1;
		pu1_s2 <= e1x_s1 * wy_s1;
		pv0_s2 <= e0x_s1 * wy_s1;
		pv1_s2 <= wx_s1 * e0y_s1;
		d_s3 <= $signed({pd0_s2[PW-1], pd0_s2}) - $signed({pd1_s2[PW-1], pd1_s2});
		nu_s3 <= $signed({pu0_s2[PW-1], pu0_s2}) - $signed({pu1_s2[PW-1], pu1_s2});
		nv_s3 <= $signed({pv0_s2[PW-1], pv0_s2}) - $signed({pv1_s2[PW-1], pv1_s2});
		d_s4 <= dn;
		ru_s4 <= mag_u;
		rv_s4 <= mag_v;
	end

	// Flip all three when the cross product d is negative so the divisor is positive.
	always_comb begin
		dneg = d_s3[CW-1];
		dn = dneg ? -d_s3 : d_s3;
		nun = dneg ? -nu_s3 : nu_s3;
		nvn = dneg ? -nv_s3 : nv_s3;
		sum_uv = $signed({nun[CW-1], nun}) + $signed({nvn[CW-1], nvn});
		mag_u = nun[CW-1] ? -nun : nun;
		mag_v = nvn[CW-1] ? -nvn : nvn;
		twice_d = {dn, 1'b0};
	end
endmodule
`default_nettype wire

// ===== rtl/core/bpt_cell.sv =====
// One restoring-division cell: yields one quotient bit for u and for v.
// Depends on bpt_pkg.
`default_nettype none
module bpt_cell #(
	parameter int MW = 35
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bpt_pkg::ctl_t               ctl_in,
	input  wire logic [MW-1:0]               d_in,
	input  wire logic [MW-1:0]               ru_in,
	input  wire logic [MW-1:0]               rv_in,
	input  wire logic [bpt_pkg::QBITS-1:0]   qu_in,
	input  wire logic [bpt_pkg::QBITS-1:0]   qv_in,
	output bpt_pkg::ctl_t                    ctl_q,
	output logic [MW-1:0]                    d_q,
	output logic [MW-1:0]                    ru_q,
	output logic [MW-1:0]                    rv_q,
	output logic [bpt_pkg::QBITS-1:0]        qu_q,
	output logic [bpt_pkg::QBITS-1:0]        qv_q
);
	logic          bu, bv;
	logic [MW-1:0] nu, nv;

	always_comb begin
		bu = (d_in <= ru_in);
		bv = (d_in <= rv_in);
		nu = bu ? ru_in - d_in : ru_in;
		nv = bv ? rv_in - d_in : rv_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= d_in;
		ru_q <= {nu[MW-2:0], 1'b0};
		rv_q <= {nv[MW-2:0], 1'b0};
		qu_q <= {qu_in[bpt_pkg::QBITS-2:0], bu};
		qv_q <= {qv_in[bpt_pkg::QBITS-2:0], bv};
	end
endmodule
`default_nettype wire

// ===== rtl/core/barycentric_point_in_triangle.sv =====
// Top level of the barycentric point-in-triangle test.
// Uses bpt_pkg, bpt_front and a chain of bpt_cell dividers.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  request  | start / busy     | ax ay bx by_coord cx cy qx qy
//  result   | done (strobe)    | inside_res degenerate weight_u weight_v
//
// One request is taken in every cycle; busy never rises. Each result
// passes through four front stages (edge vectors, products, cross products,
// sign fix and compares), fifteen division cells that each settle one
// quotient bit of u and v, and the output register. Reset clears only the
// valid bits and control flags along the pipeline. Results are shown
// for exactly one cycle with done high; the receiver cannot stall.
`default_nettype none
module barycentric_point_in_triangle #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [COORD_WIDTH-1:0] ax,
	input  wire logic [COORD_WIDTH-1:0] ay,
	input  wire logic [COORD_WIDTH-1:0] bx,
	input  wire logic [COORD_WIDTH-1:0] by_coord,
	input  wire logic [COORD_WIDTH-1:0] cx,
	input  wire logic [COORD_WIDTH-1:0] cy,
	input  wire logic [COORD_WIDTH-1:0] qx,
	input  wire logic [COORD_WIDTH-1:0] qy,
	output logic                        done,
	output logic                        inside_res,
	output logic                        degenerate,
	output logic signed [15:0]          weight_u,
	output logic signed [15:0]          weight_v
);
	localparam int MW = 2 * COORD_WIDTH + 3;
	localparam int NC = bpt_pkg::QBITS;

	bpt_pkg::ctl_t               ctl_c [NC+1];
	logic [MW-1:0]               d_c   [NC+1];
	logic [MW-1:0]               ru_c  [NC+1];
	logic [MW-1:0]               rv_c  [NC+1];
	logic [bpt_pkg::QBITS-1:0]   qu_c  [NC+1];
	logic [bpt_pkg::QBITS-1:0]   qv_c  [NC+1];
	bpt_pkg::ctl_t               cf;
	logic signed [15:0]          u_w, v_w;

	// The pipeline never holds a request back.
	assign busy = 1'b0;

	bpt_front #(.W(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord),
		.cx(cx), .cy(cy), .qx(qx), .qy(qy),
		.ctl_s4(ctl_c[0]), .d_s4(d_c[0]), .ru_s4(ru_c[0]), .rv_s4(rv_c[0])
	);

	assign qu_c[0] = '0;
	assign qv_c[0] = '0;

	// Each cell compares the running remainder with the divisor, records one
	// quotient bit and hands the doubled remainder to its neighbor.
	for (genvar i = 0; i < NC; i++) begin : g_cell
		bpt_cell #(.MW(MW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(ctl_c[i]), .d_in(d_c[i]), .ru_in(ru_c[i]), .rv_in(rv_c[i]),
			.qu_in(qu_c[i]), .qv_in(qv_c[i]),
			.ctl_q(ctl_c[i+1]), .d_q(d_c[i+1]), .ru_q(ru_c[i+1]),
			.rv_q(rv_c[i+1]), .qu_q(qu_c[i+1]), .qv_q(qv_c[i+1])
		);
	end

	assign cf = ctl_c[NC];

	// Apply saturation and sign; a degenerate triangle forces zero weights.
	always_comb begin
		if (cf.degen) begin
			u_w = '0;
		end else if (cf.sat_u) begin
			u_w = cf.neg_u ? 16'sh8000 : 16'sh7FFF;
		end else begin
			u_w = cf.neg_u ? -$signed({1'b0, qu_c[NC]}) : $signed({1'b0, qu_c[NC]});
		end
		if (cf.degen) begin
			v_w = '0;
		end else if (cf.sat_v) begin
			v_w = cf.neg_v ? 16'sh8000 : 16'sh7FFF;
		end else begin
			v_w = cf.neg_v ? -$signed({1'b0, qv_c[NC]}) : $signed({1'b0, qv_c[NC]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cf.valid;
		end
	end

	always_ff @(posedge clk) begin
		inside_res <= cf.in_tri;
		degenerate <= cf.degen;
		weight_u <= u_w;
		weight_v <= v_w;
	end
endmodule
`default_nettype wire
